@@ rtl/cstl_pkg.sv @@
// types, token codes and character classes shared by the lexer modules
`default_nettype none

package cstl_pkg;

    localparam int ID_LEN_W = 6;
    localparam int CONST_W  = 31;
    localparam int CQ_DEPTH = 4;

    localparam logic [CONST_W-1:0] CONST_MAX = 31'h7FFF_FFFF;

    localparam logic [47:0] KW_INT    = {24'h0, "int"};
    localparam logic [47:0] KW_VOID   = {16'h0, "void"};
    localparam logic [47:0] KW_RETURN = "return";

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_CONST,
        MODE_MINUS
    } lex_mode_t;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } back_state_t;

    typedef enum logic [4:0] {
        K_LBRACE     = 5'd0,
        K_RBRACE     = 5'd1,
        K_SEMI       = 5'd2,
        K_INT        = 5'd3,
        K_VOID       = 5'd4,
        K_RETURN     = 5'd5,
        K_IDENT      = 5'd6,
        K_CONST      = 5'd7,
        K_LPAREN     = 5'd8,
        K_RPAREN     = 5'd9,
        K_TILDE      = 5'd10,
        K_MINUS      = 5'd11,
        K_DEC        = 5'd12,
        K_PLUS       = 5'd13,
        K_STAR       = 5'd14,
        K_SLASH      = 5'd15,
        K_PERCENT    = 5'd16,
        K_E_INVALID  = 5'd17,
        K_E_MALFORM  = 5'd18,
        K_E_OVERFLOW = 5'd19,
        K_E_TOOLONG  = 5'd20
    } kind_t;

    typedef struct packed {
        logic                run;
        kind_t               kind;
        logic [CONST_W-1:0]  value;
        logic [ID_LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } single_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic single_t single_kind(input logic [7:0] c);
        single_t s;
        s.hit  = 1'b1;
        s.kind = K_LBRACE;
        case (c)
            "{":     s.kind = K_LBRACE;
            "}":     s.kind = K_RBRACE;
            ";":     s.kind = K_SEMI;
            "(":     s.kind = K_LPAREN;
            ")":     s.kind = K_RPAREN;
            "~":     s.kind = K_TILDE;
            "+":     s.kind = K_PLUS;
            "*":     s.kind = K_STAR;
            "/":     s.kind = K_SLASH;
            "%":     s.kind = K_PERCENT;
            default: s.hit  = 1'b0;
        endcase
        return s;
    endfunction

    // word is right-aligned, first character highest
    function automatic logic kw_char_ok(input logic [47:0] word, input logic [2:0] wlen,
                                        input logic [ID_LEN_W-1:0] pos,
                                        input logic [7:0] c);
        logic [7:0] ch;
        logic [2:0] sh;
        ch = 8'h00;
        sh = 3'd0;
        if (pos < {3'b000, wlen})
        begin
            sh = wlen - 3'd1 - pos[2:0];
            ch = word[{sh, 3'b000} +: 8];
        end
        return (pos < {3'b000, wlen}) && (c == ch);
    endfunction

endpackage

`default_nettype wire

@@ rtl/cstl_cmdq.sv @@
// short command queue between the lexer front and the token emitter
`default_nettype none

module cstl_cmdq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire cstl_pkg::cmd_t wr_data,
    input  wire logic          rd_en,
    output cstl_pkg::cmd_t     rd_data,
    output logic               q_empty,
    output logic               q_full
);
    import cstl_pkg::*;

    localparam int PTR_W = $clog2(CQ_DEPTH);
    localparam int CNT_W = $clog2(CQ_DEPTH + 1);

    cmd_t             entry_reg [CQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(CQ_DEPTH));
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/cstl_front.sv @@
// lexer front: accepts bytes, tracks the pending token and issues emit commands
`default_nettype none

module cstl_front #(
    parameter int MAX_ID_LEN = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            req_type,
    input  wire logic [7:0]                      in_byte,
    input  wire logic                            q_full,
    output logic                                 q_push,
    output cstl_pkg::cmd_t                       q_data,
    input  wire logic                            run_done,
    output logic                                 buf_we,
    output logic [$clog2(MAX_ID_LEN)-1:0]        buf_waddr,
    output logic [7:0]                           buf_wdata
);
    import cstl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ID_LEN);
    localparam int LEN_W  = $clog2(MAX_ID_LEN + 1);

    lex_mode_t          mode_reg, mode_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [2:0]         kw_reg, kw_next;
    logic [CONST_W-1:0] acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic               halted_reg, halted_next;
    logic               sec_valid_reg, sec_valid_next;
    cmd_t               sec_reg, sec_next;
    logic               run_busy_reg, run_busy_next;

    logic       accept, live;
    logic       c_alpha, c_digit, c_space, c_minus, c_word;
    single_t    sk;
    logic       f_eoi, byte_ok, extend_ident, too_long, extend_const;
    logic       malformed, dec, start, do_flush, flush_halts, cls;
    cmd_t       fc, a_cmd, b_cmd;
    logic       a_v, b_v;
    logic [34:0] acc_prod;

    assign full    = sec_valid_reg || q_full || (run_busy_reg && mode_reg != MODE_IDENT);
    assign accept  = push && !full;
    assign live    = accept && !halted_reg;

    assign c_alpha = is_alpha(in_byte);
    assign c_digit = is_digit(in_byte);
    assign c_space = is_space(in_byte);
    assign c_minus = (in_byte == "-");
    assign c_word  = c_alpha || c_digit;
    assign sk      = single_kind(in_byte);

    assign f_eoi        = live && req_type;
    assign byte_ok      = live && !req_type;
    assign extend_ident = byte_ok && mode_reg == MODE_IDENT && c_word;
    assign too_long     = extend_ident && (len_reg >= LEN_W'(MAX_ID_LEN));
    assign extend_const = byte_ok && mode_reg == MODE_CONST && c_digit;
    assign malformed    = byte_ok && mode_reg == MODE_CONST && c_alpha;
    assign dec          = byte_ok && mode_reg == MODE_MINUS && c_minus;
    assign start        = byte_ok && !(mode_reg == MODE_IDENT && c_word)
                          && !(mode_reg == MODE_CONST && c_word) && !dec;
    assign do_flush     = f_eoi || start;
    assign flush_halts  = do_flush && mode_reg == MODE_CONST && ovf_reg;
    assign cls          = start && !flush_halts;

    assign acc_prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                      + {31'b0, in_byte[3:0] - 4'd0};

    // pending token as it would be emitted now
    always_comb
    begin
        fc = '0;
        unique case (mode_reg)
            MODE_IDENT:
            begin
                if (kw_reg[0] && len_reg == LEN_W'(3))
                begin
                    fc.kind = K_INT;
                end
                else if (kw_reg[1] && len_reg == LEN_W'(4))
                begin
                    fc.kind = K_VOID;
                end
                else if (kw_reg[2] && len_reg == LEN_W'(6))
                begin
                    fc.kind = K_RETURN;
                end
                else
                begin
                    fc.run  = 1'b1;
                    fc.kind = K_IDENT;
                    fc.len  = ID_LEN_W'(len_reg);
                end
            end
            MODE_CONST:
            begin
                if (ovf_reg)
                begin
                    fc.kind = K_E_OVERFLOW;
                end
                else
                begin
                    fc.kind  = K_CONST;
                    fc.value = acc_reg;
                end
            end
            MODE_MINUS:
            begin
                fc.kind = K_MINUS;
            end
            default:
            begin
                fc = '0;
            end
        endcase
    end

    // lexer mode
    always_comb
    begin
        mode_next = mode_reg;
        if (f_eoi || flush_halts || too_long || malformed || dec)
        begin
            mode_next = MODE_IDLE;
        end
        else if (cls)
        begin
            if (c_alpha)
            begin
                mode_next = MODE_IDENT;
            end
            else if (c_digit)
            begin
                mode_next = MODE_CONST;
            end
            else if (c_minus)
            begin
                mode_next = MODE_MINUS;
            end
            else
            begin
                mode_next = MODE_IDLE;
            end
        end
    end

    // commands, accumulators and buffer writes
    always_comb
    begin
        a_cmd       = fc;
        a_v         = do_flush && mode_reg != MODE_IDLE;
        b_cmd       = '0;
        b_v         = 1'b0;
        halted_next = halted_reg || flush_halts;
        len_next    = len_reg;
        kw_next     = kw_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        buf_we      = 1'b0;
        buf_waddr   = ADDR_W'(0);
        buf_wdata   = in_byte;

        if (do_flush && mode_reg == MODE_IDENT)
        begin
            len_next = '0;
        end

        if (too_long)
        begin
            b_v         = 1'b1;
            b_cmd.kind  = K_E_TOOLONG;
            halted_next = 1'b1;
        end
        else if (extend_ident)
        begin
            buf_we    = 1'b1;
            buf_waddr = len_reg[ADDR_W-1:0];
            len_next  = len_reg + LEN_W'(1);
            kw_next   = kw_reg & {kw_char_ok(KW_RETURN, 3'd6, ID_LEN_W'(len_reg), in_byte),
                                  kw_char_ok(KW_VOID, 3'd4, ID_LEN_W'(len_reg), in_byte),
                                  kw_char_ok(KW_INT, 3'd3, ID_LEN_W'(len_reg), in_byte)};
        end

        if (extend_const && !ovf_reg)
        begin
            if (acc_prod > {4'b0, CONST_MAX})
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = acc_prod[CONST_W-1:0];
            end
        end

        if (malformed)
        begin
            b_v         = 1'b1;
            b_cmd.kind  = K_E_MALFORM;
            halted_next = 1'b1;
        end

        if (dec)
        begin
            b_v        = 1'b1;
            b_cmd.kind = K_DEC;
        end

        if (cls && !c_space)
        begin
            if (c_alpha)
            begin
                buf_we   = 1'b1;
                len_next = LEN_W'(1);
                kw_next  = {kw_char_ok(KW_RETURN, 3'd6, ID_LEN_W'(0), in_byte),
                            kw_char_ok(KW_VOID, 3'd4, ID_LEN_W'(0), in_byte),
                            kw_char_ok(KW_INT, 3'd3, ID_LEN_W'(0), in_byte)};
            end
            else if (c_digit)
            begin
                acc_next = CONST_W'(in_byte[3:0]);
                ovf_next = 1'b0;
            end
            else if (!c_minus)
            begin
                b_v = 1'b1;
                if (sk.hit)
                begin
                    b_cmd.kind = sk.kind;
                end
                else
                begin
                    b_cmd.kind  = K_E_INVALID;
                    halted_next = 1'b1;
                end
            end
        end

        if (sec_valid_reg)
        begin
            q_push         = !q_full;
            q_data         = sec_reg;
            sec_valid_next = q_full;
            sec_next       = sec_reg;
        end
        else
        begin
            q_push         = a_v || b_v;
            q_data         = a_v ? a_cmd : b_cmd;
            sec_valid_next = a_v && b_v;
            sec_next       = b_cmd;
        end

        if (a_v && a_cmd.run)
        begin
            run_busy_next = 1'b1;
        end
        else if (run_done)
        begin
            run_busy_next = 1'b0;
        end
        else
        begin
            run_busy_next = run_busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            len_reg       <= '0;
            kw_reg        <= '0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            halted_reg    <= 1'b0;
            sec_valid_reg <= 1'b0;
            run_busy_reg  <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            kw_reg        <= kw_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            halted_reg    <= halted_next;
            sec_valid_reg <= sec_valid_next;
            run_busy_reg  <= run_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_reg <= sec_next;
    end

endmodule

`default_nettype wire

@@ rtl/cstl_back.sv @@
// token emitter: turns commands into result items, reads identifier runs from the buffer
`default_nettype none

module cstl_back #(
    parameter int MAX_ID_LEN = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_empty,
    input  wire cstl_pkg::cmd_t                     q_data,
    output logic                                    q_pop,
    input  wire logic                               buf_we,
    input  wire logic [$clog2(MAX_ID_LEN)-1:0]      buf_waddr,
    input  wire logic [7:0]                         buf_wdata,
    output logic                                    run_done,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [4:0]                              token_kind,
    output logic [30:0]                             const_value,
    output logic [7:0]                              ident_char,
    output logic                                    last_of_run
);
    import cstl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ID_LEN);

    logic [7:0]          id_mem [MAX_ID_LEN];
    logic [7:0]          rd_data_reg;

    back_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ID_LEN_W-1:0] len_reg, len_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [CONST_W-1:0]  out_value_reg, out_value_next;
    logic [7:0]          out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    logic                can_load, is_last, rd_en;
    logic [ADDR_W-1:0]   rd_addr;

    assign can_load = !out_valid_reg || pop;
    assign is_last  = (7'(idx_reg) + 7'd1 == 7'(len_reg));

    assign empty       = !out_valid_reg;
    assign token_kind  = out_kind_reg;
    assign const_value = out_value_reg;
    assign ident_char  = out_char_reg;
    assign last_of_run = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && q_data.run)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (can_load && is_last)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = ADDR_W'(0);
        run_done       = 1'b0;
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !pop;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.run)
                    begin
                        q_pop    = 1'b1;
                        rd_en    = 1'b1;
                        idx_next = '0;
                        len_next = q_data.len;
                    end
                    else if (can_load)
                    begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        out_kind_next  = q_data.kind;
                        out_value_next = q_data.value;
                        out_char_next  = 8'h00;
                        out_last_next  = 1'b1;
                    end
                end
            end
            B_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = K_IDENT;
                    out_value_next = '0;
                    out_char_next  = rd_data_reg;
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        run_done = 1'b1;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + ADDR_W'(1);
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            id_mem[buf_waddr] <= buf_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= id_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/c_subset_token_lexer.sv @@
// top level of the token lexer: front, command queue and emitter
// items go through the queue and output register, runs also the buffer read register; bytes
// are taken one a cycle while full is low, and a byte that ends one token and yields another
// holds input until the second is queued; a run leaves one character a cycle while pop frees
// the output, holding input to its end unless an identifier is open; an error halts the lexer
// until reset; reset clears control state, not the identifier buffer, which needs no clearing pass
`default_nettype none

module c_subset_token_lexer #(
    parameter int MAX_ID_LEN = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        req_type,
    input  wire logic [7:0]  in_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [4:0]       token_kind,
    output logic [30:0]      const_value,
    output logic [7:0]       ident_char,
    output logic             last_of_run
);
    import cstl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ID_LEN);

    cmd_t              f_cmd, q_cmd;
    logic              f_push, q_pop, q_empty, q_full;
    logic              run_done, buf_we;
    logic [ADDR_W-1:0] buf_waddr;
    logic [7:0]        buf_wdata;

    cstl_front #(
        .MAX_ID_LEN (MAX_ID_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .in_byte   (in_byte),
        .q_full    (q_full),
        .q_push    (f_push),
        .q_data    (f_cmd),
        .run_done  (run_done),
        .buf_we    (buf_we),
        .buf_waddr (buf_waddr),
        .buf_wdata (buf_wdata)
    );

    cstl_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_cmd),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    cstl_back #(
        .MAX_ID_LEN (MAX_ID_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_cmd),
        .q_pop       (q_pop),
        .buf_we      (buf_we),
        .buf_waddr   (buf_waddr),
        .buf_wdata   (buf_wdata),
        .run_done    (run_done),
        .empty       (empty),
        .pop         (pop),
        .token_kind  (token_kind),
        .const_value (const_value),
        .ident_char  (ident_char),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

@@ dv/tb_c_subset_token_lexer.sv @@
// self-checking testbench for the c subset token lexer with a built-in token predictor

module tb_c_subset_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import cstl_pkg::*;

    localparam int ID_MAX     = 32;
    localparam int ITEMS      = 500;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 20;

    typedef struct {
        logic       eof;
        logic [7:0] data;
        logic       drain;
    } src_item_t;

    typedef struct {
        kind_t       kind;
        logic [30:0] value;
        logic [7:0]  ch;
        logic        last;
    } token_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        req_type = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [4:0]  token_kind;
    logic [30:0] const_value;
    logic [7:0]  ident_char;
    logic        last_of_run;

    src_item_t   byte_q[$];
    token_t      token_q[$];
    logic        drain_next = 1'b0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;

    string       punct_set = "{}();~+*/%-";
    string       kw_words [10] = '{"int", "void", "return", "in", "vo", "retur", "ints",
                                   "voids", "Return", "_"};

    // predictor state
    lex_mode_t   scan_mode = MODE_IDLE;
    logic [7:0]  id_buf [ID_MAX];
    int          id_len = 0;
    logic [30:0] num_acc = '0;
    logic        num_ovf = 1'b0;
    logic        halted = 1'b0;

    c_subset_token_lexer #(.MAX_ID_LEN(ID_MAX)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .in_byte     (in_byte),
        .empty       (empty),
        .pop         (pop),
        .token_kind  (token_kind),
        .const_value (const_value),
        .ident_char  (ident_char),
        .last_of_run (last_of_run)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic letter_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank_ch(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic byte_known(logic [7:0] c);
        int i;
        for (i = 0; i < punct_set.len(); i++)
            if (punct_set[i] == c)
                return 1'b1;
        return letter_ch(c) || digit_ch(c) || blank_ch(c);
    endfunction

    function automatic void emit(kind_t k, logic [30:0] v, logic [7:0] c, logic last);
        token_t t;
        t.kind  = k;
        t.value = v;
        t.ch    = c;
        t.last  = last;
        token_q.insert(token_q.size(), t);
    endfunction

    function automatic void raise_err(kind_t k);
        halted    = 1'b1;
        scan_mode = MODE_IDLE;
        emit(k, '0, '0, 1'b1);
    endfunction

    function automatic logic word_is(string w);
        int i;
        if (id_len != w.len())
            return 1'b0;
        for (i = 0; i < w.len(); i++)
            if (id_buf[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void flush_pending();
        int i;
        case (scan_mode)
            MODE_IDENT:
            begin
                if (word_is("int"))
                    emit(K_INT, '0, '0, 1'b1);
                else if (word_is("void"))
                    emit(K_VOID, '0, '0, 1'b1);
                else if (word_is("return"))
                    emit(K_RETURN, '0, '0, 1'b1);
                else
                    for (i = 0; i < id_len; i++)
                        emit(K_IDENT, '0, id_buf[i], i == id_len - 1);
                id_len = 0;
            end
            MODE_CONST:
            begin
                if (num_ovf)
                begin
                    raise_err(K_E_OVERFLOW);
                    return;
                end
                emit(K_CONST, num_acc, '0, 1'b1);
                num_acc = '0;
            end
            MODE_MINUS:
                emit(K_MINUS, '0, '0, 1'b1);
            default: ;
        endcase
        scan_mode = MODE_IDLE;
    endfunction

    function automatic void lex_item(logic eof, logic [7:0] c);
        logic [63:0] wide;
        if (halted)
            return;
        if (eof)
        begin
            flush_pending();
            return;
        end
        case (scan_mode)
            MODE_IDENT:
            begin
                if (letter_ch(c) || digit_ch(c))
                begin
                    if (id_len >= ID_MAX)
                        raise_err(K_E_TOOLONG);
                    else
                    begin
                        id_buf[id_len] = c;
                        id_len++;
                    end
                    return;
                end
                flush_pending();
            end
            MODE_CONST:
            begin
                if (digit_ch(c))
                begin
                    if (!num_ovf)
                    begin
                        wide = {33'd0, num_acc} * 64'd10 + {56'd0, c} - 64'd48;
                        if (wide > {33'd0, CONST_MAX})
                            num_ovf = 1'b1;
                        else
                            num_acc = wide[30:0];
                    end
                    return;
                end
                if (letter_ch(c))
                begin
                    raise_err(K_E_MALFORM);
                    return;
                end
                flush_pending();
                if (halted)
                    return;
            end
            MODE_MINUS:
            begin
                if (c == "-")
                begin
                    scan_mode = MODE_IDLE;
                    emit(K_DEC, '0, '0, 1'b1);
                    return;
                end
                flush_pending();
            end
            default: ;
        endcase
        if (blank_ch(c))
            return;
        if (letter_ch(c))
        begin
            scan_mode = MODE_IDENT;
            id_buf[0] = c;
            id_len    = 1;
            return;
        end
        if (digit_ch(c))
        begin
            scan_mode = MODE_CONST;
            num_acc   = {23'd0, c - 8'd48};
            num_ovf   = 1'b0;
            return;
        end
        case (c)
            "-": scan_mode = MODE_MINUS;
            "{": emit(K_LBRACE, '0, '0, 1'b1);
            "}": emit(K_RBRACE, '0, '0, 1'b1);
            ";": emit(K_SEMI, '0, '0, 1'b1);
            "(": emit(K_LPAREN, '0, '0, 1'b1);
            ")": emit(K_RPAREN, '0, '0, 1'b1);
            "~": emit(K_TILDE, '0, '0, 1'b1);
            "+": emit(K_PLUS, '0, '0, 1'b1);
            "*": emit(K_STAR, '0, '0, 1'b1);
            "/": emit(K_SLASH, '0, '0, 1'b1);
            "%": emit(K_PERCENT, '0, '0, 1'b1);
            default: raise_err(K_E_INVALID);
        endcase
    endfunction

    function automatic logic [7:0] rand_word_char(logic lead);
        int k;
        k = $urandom_range(0, lead ? 52 : 62);
        if (k < 26)
            return 8'(k + 97);
        if (k < 52)
            return 8'(k - 26 + 65);
        if (k == 52)
            return "_";
        return 8'(k - 53 + 48);
    endfunction

    task automatic put_item(logic eof, logic [7:0] b);
        src_item_t it;
        it.eof   = eof;
        it.data  = b;
        it.drain = drain_next;
        drain_next = 1'b0;
        byte_q.insert(byte_q.size(), it);
    endtask

    task automatic put_byte(logic [7:0] b);
        put_item(1'b0, b);
    endtask

    task automatic put_eof();
        put_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_space();
        int b;
        b = $urandom_range(8, 13);
        put_byte(b == 8 ? 8'd32 : 8'(b));
    endtask

    task automatic put_punct();
        put_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
    endtask

    task automatic put_sep();
        case ($urandom_range(0, 2))
            0: put_space();
            1: put_punct();
            default: put_eof();
        endcase
    endtask

    task automatic put_ident(int len);
        int i;
        put_byte(rand_word_char(1'b1));
        for (i = 1; i < len; i++)
            put_byte(rand_word_char(1'b0));
    endtask

    task automatic put_const(longint unsigned v);
        if ($urandom_range(0, 7) == 0)
            put_byte("0");
        put_text($sformatf("%0d", v));
    endtask

    // source side: bursts of items with random gaps, optional wait for results to drain
    always @(posedge clk or negedge rst_n)
    begin : feed
        src_item_t nxt;
        logic      took;
        if (!rst_n)
        begin
            push     <= 1'b0;
            req_type <= 1'b0;
            in_byte  <= 8'h00;
        end
        else
        begin
            took = push && !full;
            if (took)
                lex_item(req_type, in_byte);
            if (!push || took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (byte_q.size() != 0 && !(byte_q[0].drain && token_q.size() != 0))
                begin
                    nxt = byte_q.pop_front();
                    push     <= 1'b1;
                    req_type <= nxt.eof;
                    in_byte  <= nxt.data;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                                 : $urandom_range(1, 12);
                        if ($urandom_range(0, 19) == 0)
                            gap_left = $urandom_range(20, 40);
                        else if ($urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 6);
                    end
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result side: compare against predicted tokens, stall in phases
    always @(posedge clk or negedge rst_n)
    begin : watch
        token_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (token_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected item, expected none got kind %0d", $time,
                             token_kind);
                end
                else
                begin
                    want = token_q.pop_front();
                    if (token_kind !== want.kind)
                    begin
                        mismatches++;
                        $display("%0t ns: token_kind expected %0d got %0d", $time,
                                 want.kind, token_kind);
                    end
                    if (const_value !== want.value)
                    begin
                        mismatches++;
                        $display("%0t ns: const_value expected %0d got %0d", $time,
                                 want.value, const_value);
                    end
                    if (ident_char !== want.ch)
                    begin
                        mismatches++;
                        $display("%0t ns: ident_char expected %0h got %0h", $time,
                                 want.ch, ident_char);
                    end
                    if (last_of_run !== want.last)
                    begin
                        mismatches++;
                        $display("%0t ns: last_of_run expected %0b got %0b", $time,
                                 want.last, last_of_run);
                    end
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(32, 200);
            end
            else
                stall_left--;
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[c_subset_token_lexer] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int              r;
        longint unsigned v;
        logic [7:0]      b;

        // keywords, every operator, decrement then minus
        put_text("int\tvoid\nreturn{}();~+*/%---");
        put_eof();

        // extremes: longest identifier, largest and smallest constant, flushes
        drain_next = 1'b1;
        put_ident(ID_MAX);
        put_sep();
        put_const(CONST_MAX);
        put_sep();
        put_const(0);
        put_eof();
        put_text("007-");
        put_eof();
        put_eof();
        put_byte(8'd11);
        put_byte(8'd12);
        put_byte(8'd13);
        put_byte(8'd32);

        while (byte_q.size() < ITEMS)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0)
                drain_next = 1'b1;
            if (r < 30)
            begin
                if ($urandom_range(0, 9) == 0)
                    put_text(kw_words[$urandom_range(0, 9)]);
                else
                    put_ident(($urandom_range(0, 15) == 0) ? $urandom_range(9, ID_MAX)
                                                            : $urandom_range(1, 8));
                put_sep();
            end
            else if (r < 50)
            begin
                case ($urandom_range(0, 3))
                    0: v = $urandom_range(0, 9);
                    1: v = $urandom_range(10, 99999);
                    2: v = $urandom_range(0, CONST_MAX);
                    default: v = CONST_MAX - $urandom_range(0, 9);
                endcase
                put_const(v);
                put_sep();
            end
            else if (r < 80)
            begin
                if ($urandom_range(0, 4) == 0)
                    put_text("--");
                else
                    put_punct();
            end
            else if (r < 90)
                repeat ($urandom_range(1, 3)) put_space();
            else if (r < 95)
                put_eof();
            else
                repeat ($urandom_range(1, 4))
                    case ($urandom_range(0, 2))
                        0: put_space();
                        1: put_punct();
                        default: put_eof();
                    endcase
        end

        // one error halts the lexer for the rest of the run
        drain_next = 1'b1;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: put_ident($urandom_range(1, 6));
                    2: put_const($urandom_range(0, 9999));
                    default: put_byte("-");
                endcase
                do
                    b = 8'($urandom_range(0, 255));
                while (byte_known(b));
                put_byte(b);
            end
            1:
            begin
                if ($urandom_range(0, 1) == 0)
                    put_const(64'd2147483648 + $urandom_range(0, 99999999));
                else
                    put_const($urandom_range(0, 99999));
                put_byte(rand_word_char(1'b1));
            end
            2:
            begin
                put_const(64'd2147483648 + $urandom_range(0, 99999999));
                put_sep();
            end
            default:
                put_ident(ID_MAX + 1);
        endcase
        repeat (3)
        begin
            if ($urandom_range(0, 1) == 0)
                put_eof();
            else
                put_byte(8'($urandom_range(0, 255)));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (byte_q.size() == 0 && !push && token_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && token_q.size() == 0)
            $display("[c_subset_token_lexer] OK");
        else
            $display("[c_subset_token_lexer] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cstl_pkg.sv
rtl/cstl_cmdq.sv
rtl/cstl_front.sv
rtl/cstl_back.sv
rtl/c_subset_token_lexer.sv
dv/tb_c_subset_token_lexer.sv
